>>> hdl/mwdt_pkg.sv
package mwdt_pkg;

    localparam int unsigned CORES_DEF   = 4;

    localparam int unsigned ACT_W       = 3;
    localparam int unsigned CORE_ID_W   = 2;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned CNT_W       = 20;
    localparam int unsigned MARK_W      = 4;
    localparam int unsigned TIMEOUT_W   = 6;

    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 6;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 32;

    // 65536 ticks per second -> shift by 16
    localparam int unsigned TICK_SHIFT  = 16;
    localparam logic [TIMEOUT_W-1:0] MAX_TIMEOUT_S = TIMEOUT_W'(15);
    localparam logic [CNT_W-1:0]     FORCE_TICKS   = CNT_W'(10);

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_KICK    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DISABLE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ARM     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FORCE   = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_INIT = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTICORE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_MASK  = 2'd2;

    typedef struct packed {
        logic                 counting;
        logic [MARK_W-1:0]    cores_reported;
        logic                 caused_by_watchdog;
        logic                 reset_pulse;
        logic [CNT_W-1:0]     count_now;
        logic [STATUS_W-1:0]  status;
    } t_result;

endpackage

>>> hdl/mwdt_core.sv
module mwdt_core #(
    parameter int unsigned CORES = mwdt_pkg::CORES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mwdt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mwdt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_take,
    input  logic [mwdt_pkg::ACT_W-1:0]      i_action,
    input  logic [mwdt_pkg::CORE_ID_W-1:0]  i_core_id,
    output mwdt_pkg::t_result               o_res
);
    import mwdt_pkg::*;

    localparam logic [MARK_W-1:0] CMASK =
        (CORES >= MARK_W) ? {MARK_W{1'b1}} : MARK_W'((1 << CORES) - 1);

    logic [TIMEOUT_W-1:0] r_timeout;
    logic                 r_multicore;
    logic [MARK_W-1:0]    r_exp_mask;

    logic [CNT_W-1:0]  r_count,  n_count;
    logic [CNT_W-1:0]  r_reload, n_reload;
    logic              r_armed,  n_armed;
    logic              r_init,   n_init;
    logic [MARK_W-1:0] r_marks,  n_marks;
    logic              r_sticky, n_sticky;

    logic [STATUS_W-1:0]  status;
    logic                 pulse;
    logic [CNT_W-1:0]     cnt_dec;
    logic [MARK_W-1:0]    marks_or;
    logic [TIMEOUT_W-1:0] t_clamp;

    always_comb begin
        cnt_dec  = (r_count != '0) ? r_count - CNT_W'(1) : r_count;
        marks_or = r_marks | ((MARK_W'(1) << i_core_id) & CMASK);
        t_clamp  = (r_timeout > MAX_TIMEOUT_S) ? MAX_TIMEOUT_S : r_timeout;

        n_count  = r_count;
        n_reload = r_reload;
        n_armed  = r_armed;
        n_init   = r_init;
        n_marks  = r_marks;
        n_sticky = r_sticky;
        status   = ST_OK;
        pulse    = 1'b0;

        case (i_action)
            ACT_TICK: begin
                if (r_armed) begin
                    n_count = cnt_dec;
                    if (cnt_dec == '0) begin
                        pulse    = 1'b1;
                        n_sticky = 1'b1;
                        n_armed  = 1'b0;
                    end
                end
            end
            ACT_KICK: begin
                if (!r_init) begin
                    status = ST_NOT_INIT;
                end else if (!r_multicore) begin
                    n_count = r_reload;
                end else begin
                    n_marks = marks_or;
                    // round done once every expected core has a mark
                    if (((r_exp_mask & CMASK) & ~marks_or) == '0) begin
                        n_marks = '0;
                        n_count = r_reload;
                    end
                end
            end
            ACT_DISABLE: begin
                n_armed = 1'b0;
            end
            ACT_ARM: begin
                if (r_timeout == '0) begin
                    status = ST_INVALID;
                end else begin
                    // clamped value <= 15, so seconds << 16 fits in 20 bits
                    n_reload = {t_clamp[CNT_W-TICK_SHIFT-1:0], {TICK_SHIFT{1'b0}}};
                    n_count  = {t_clamp[CNT_W-TICK_SHIFT-1:0], {TICK_SHIFT{1'b0}}};
                    n_armed  = 1'b1;
                    n_init   = 1'b1;
                end
            end
            ACT_FORCE: begin
                n_count = FORCE_TICKS;
                n_armed = 1'b1;
            end
            default: begin
            end
        endcase

        o_res.status             = status;
        o_res.count_now          = n_count;
        o_res.reset_pulse        = pulse;
        o_res.caused_by_watchdog = n_sticky;
        o_res.cores_reported     = n_marks;
        o_res.counting           = n_armed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= '0;
            r_multicore <= 1'b0;
            r_exp_mask  <= '0;
            r_count     <= '0;
            r_reload    <= '0;
            r_armed     <= 1'b0;
            r_init      <= 1'b0;
            r_marks     <= '0;
            r_sticky    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                    CFG_MULTICORE: r_multicore <= i_cfg_data[0];
                    CFG_EXP_MASK:  r_exp_mask  <= i_cfg_data[MARK_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_take) begin
                r_count  <= n_count;
                r_reload <= n_reload;
                r_armed  <= n_armed;
                r_init   <= n_init;
                r_marks  <= n_marks;
                r_sticky <= n_sticky;
            end
        end
    end

    // expiry always disarms and latches the cause flag
    a_expire_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_action == ACT_TICK && r_armed && r_count <= CNT_W'(1))
        |=> (!r_armed && r_sticky))
        else $error("expiry did not disarm");

    a_sticky_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sticky |=> r_sticky)
        else $error("cause flag cleared without reset");

    a_no_init_no_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_init |-> (r_reload == '0 && r_marks == '0))
        else $error("reload or marks set before first arm");

    a_marks_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_marks & ~CMASK) == '0)
        else $error("mark set for a core that does not exist");

endmodule

>>> hdl/mwdt_obuf.sv
module mwdt_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mwdt_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free,
    output mwdt_pkg::t_result o_res
);
    import mwdt_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or being drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !i_load)
        else $error("result overwritten while stalled");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded result not presented");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_res)))
        else $error("stalled result changed");

endmodule

>>> hdl/multicore_watchdog_timer.sv
// Channel   Dir  Handshake                  Payload (low bit first)
// s_axis    in   s_axis_tvalid/tready       action[2:0], core_id[4:3]
// m_axis    out  m_axis_tvalid/tready       status, count_now, reset_pulse,
//                                           caused_by_watchdog, cores_reported,
//                                           counting
// cfg       in   i_cfg_we (no ready)        i_cfg_idx, i_cfg_data
//
// One transaction per cycle while the result register is free; its result appears in the cycle after acceptance.
// The single result register after the state update logic holds each result.
// Reset is synchronous, active low; it clears all state and config registers.
// A stalled result holds; input is still taken whenever the result register
// empties in the same cycle.
module multicore_watchdog_timer #(
    parameter int unsigned CORES = mwdt_pkg::CORES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mwdt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mwdt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // action[2:0], core_id[4:3], zero pad [7:5]
    input  logic [mwdt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status[1:0], count_now[21:2], reset_pulse[22], caused_by_watchdog[23],
    // cores_reported[27:24], counting[28], zero pad [31:29]
    output logic [mwdt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import mwdt_pkg::*;

    logic    free;
    logic    take;
    t_result core_res;
    t_result out_res;

    assign s_axis_tready = free;
    assign take          = s_axis_tvalid && free;

    // all state changes happen in the accept cycle
    mwdt_core #(
        .CORES (CORES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .i_action   (s_axis_tdata[ACT_W-1:0]),
        .i_core_id  (s_axis_tdata[ACT_W+CORE_ID_W-1:ACT_W]),
        .o_res      (core_res)
    );

    mwdt_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_res   (core_res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_free  (free),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, out_res};

endmodule

>>> bench/mwdt_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both stream channels, keeps its own copy of the
// watchdog state and compares every result transaction against it.
module mwdt_checker #(
    parameter int unsigned CORES = mwdt_pkg::CORES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mwdt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mwdt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    // action[2:0], core_id[4:3]
    input  logic [mwdt_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // status[1:0], count_now[21:2], reset_pulse[22], caused_by_watchdog[23],
    // cores_reported[27:24], counting[28]
    input  logic [mwdt_pkg::OUT_TDATA_W-1:0]  i_m_tdata,
    output int                                o_fail_count,
    output int                                o_pending
);
    import mwdt_pkg::*;

    // core ids at or above CORES never mark and never count as expected
    localparam logic [MARK_W-1:0] CORE_FIELD =
        (CORES >= MARK_W) ? {MARK_W{1'b1}} : MARK_W'((1 << CORES) - 1);

    logic [TIMEOUT_W-1:0] timeout_reg     = '0;
    logic                 multicore_reg   = 1'b0;
    logic [MARK_W-1:0]    core_mask_reg   = '0;

    logic [CNT_W-1:0]     countdown       = '0;
    logic [CNT_W-1:0]     reload_ticks    = '0;
    logic                 armed           = 1'b0;
    logic                 initialized     = 1'b0;
    logic [MARK_W-1:0]    kick_marks      = '0;
    logic                 sticky_cause    = 1'b0;

    t_result              watchdog_expect_q[$];
    int                   fails           = 0;

    assign o_fail_count = fails;

    task automatic step_watchdog(input logic [ACT_W-1:0] act,
                                 input logic [CORE_ID_W-1:0] core,
                                 output t_result res);
        logic [TIMEOUT_W-1:0] secs;
        logic [STATUS_W-1:0]  st;
        logic                 pulse;
        st    = ST_OK;
        pulse = 1'b0;
        case (act)
            ACT_TICK: begin
                if (armed) begin
                    if (countdown != '0)
                        countdown = countdown - 1'b1;
                    if (countdown == '0) begin
                        pulse        = 1'b1;
                        sticky_cause = 1'b1;
                        armed        = 1'b0;
                    end
                end
            end
            ACT_KICK: begin
                if (!initialized) begin
                    st = ST_NOT_INIT;
                end else if (!multicore_reg) begin
                    countdown = reload_ticks;
                end else begin
                    kick_marks = kick_marks | ((MARK_W'(1) << core) & CORE_FIELD);
                    if ((core_mask_reg & CORE_FIELD & ~kick_marks) == '0) begin
                        kick_marks = '0;
                        countdown  = reload_ticks;
                    end
                end
            end
            ACT_DISABLE: begin
                armed = 1'b0;
            end
            ACT_ARM: begin
                if (timeout_reg == '0) begin
                    st = ST_INVALID;
                end else begin
                    secs = (timeout_reg > MAX_TIMEOUT_S) ? MAX_TIMEOUT_S : timeout_reg;
                    reload_ticks = CNT_W'(32'(secs) << TICK_SHIFT);
                    countdown    = reload_ticks;
                    armed        = 1'b1;
                    initialized  = 1'b1;
                end
            end
            ACT_FORCE: begin
                countdown = FORCE_TICKS;
                armed     = 1'b1;
            end
            default: ;
        endcase
        res.status             = st;
        res.count_now          = countdown;
        res.reset_pulse        = pulse;
        res.caused_by_watchdog = sticky_cause;
        res.cores_reported     = kick_marks;
        res.counting           = armed;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result seen;
        if (!i_rst_n) begin
            timeout_reg   = '0;
            multicore_reg = 1'b0;
            core_mask_reg = '0;
            countdown     = '0;
            reload_ticks  = '0;
            armed         = 1'b0;
            initialized   = 1'b0;
            kick_marks    = '0;
            sticky_cause  = 1'b0;
            watchdog_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIMEOUT:   timeout_reg   = i_cfg_data[TIMEOUT_W-1:0];
                    CFG_MULTICORE: multicore_reg = i_cfg_data[0];
                    CFG_EXP_MASK:  core_mask_reg = i_cfg_data[MARK_W-1:0];
                    default: ;
                endcase
            end
            // pop before push: a result never belongs to the input taken on the same edge
            if (i_m_tvalid && i_m_tready) begin
                seen = i_m_tdata[$bits(t_result)-1:0];
                if (watchdog_expect_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fails++;
                end else begin
                    want = watchdog_expect_q.pop_front();
                    check_field("status", want.status, seen.status);
                    check_field("count_now", want.count_now, seen.count_now);
                    check_field("reset_pulse", want.reset_pulse, seen.reset_pulse);
                    check_field("caused_by_watchdog", want.caused_by_watchdog,
                                seen.caused_by_watchdog);
                    check_field("cores_reported", want.cores_reported,
                                seen.cores_reported);
                    check_field("counting", want.counting, seen.counting);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                step_watchdog(i_s_tdata[ACT_W-1:0], i_s_tdata[ACT_W +: CORE_ID_W], want);
                watchdog_expect_q.push_back(want);
            end
        end
        o_pending <= watchdog_expect_q.size();
    end

endmodule

>>> bench/tb_multicore_watchdog_timer.sv
`timescale 1ns / 1ps

module tb_multicore_watchdog_timer;
    import mwdt_pkg::*;

    // first action code the block does not decode; everything above it is unused too
    localparam logic [ACT_W-1:0] ACT_SPARE   = ACT_FORCE + 3'd1;
    localparam int               N_PHASES    = 8;
    localparam int               PHASE_ITEMS = 100;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // action[2:0], core_id[4:3]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // status[1:0], count_now[21:2], reset_pulse[22], caused_by_watchdog[23],
    // cores_reported[27:24], counting[28]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int   fail_count;
    int   pending;
    int   items_sent = 0;
    logic src_calm   = 1'b0;   // phase-wide: source sends back to back
    logic sink_calm  = 1'b0;   // sink never stalls while set
    int   sink_hold  = 0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    multicore_watchdog_timer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mwdt_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Gap lengths: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result sink: random stalls, with occasional stall-free stretches.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0)
            sink_calm <= ~sink_calm;
        if (sink_hold > 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            sink_hold     <= sink_calm ? 0 : pick_gap();
        end
    end

    // One input transaction. Called right after a rising edge; a gap lowers
    // tvalid, otherwise the next item follows back to back with tvalid held.
    task automatic send_op(input logic [ACT_W-1:0] act, input logic [CORE_ID_W-1:0] core);
        int gap;
        gap = src_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - ACT_W - CORE_ID_W){1'b0}}, core, act};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Drop tvalid and wait until every predicted result has been taken.
    // The checker's count is registered, so read it only after its register has updated.
    task automatic wait_quiet(input int limit);
        int k;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        for (k = 0; k < limit && pending != 0; k++)
            @(posedge i_clk);
        // margin past the single result register
        repeat (3) @(posedge i_clk);
    endtask

    // Writes all three registers on consecutive edges, enable held high.
    task automatic write_cfg(input logic [TIMEOUT_W-1:0] secs, input logic multi,
                             input logic [MARK_W-1:0] mask);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TIMEOUT;
        i_cfg_data <= CFG_DATA_W'(secs);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MULTICORE;
        i_cfg_data <= CFG_DATA_W'(multi);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_EXP_MASK;
        i_cfg_data <= CFG_DATA_W'(mask);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_directed();
        int a;
        // registers still at reset: zero timeout, single core
        send_op(ACT_KICK, '0);        // kick before any arm -> not initialized
        send_op(ACT_ARM, '1);         // zero timeout -> invalid, nothing moves
        send_op(ACT_TICK, '0);        // disarmed tick is a no-op
        for (a = int'(ACT_SPARE); a < (1 << ACT_W); a++)
            send_op(ACT_W'(a), CORE_ID_W'(a));
        send_op(ACT_FORCE, '0);       // short countdown of ten, armed
        repeat (10) send_op(ACT_TICK, '0);   // last one expires: pulse + sticky
        send_op(ACT_TICK, '1);        // after expiry the block is disarmed
        send_op(ACT_KICK, '1);        // force-reset does not initialize
        wait_quiet(1000);

        // largest timeout (clamped to 15 s), multicore, every core expected
        write_cfg('1, 1'b1, '1);
        send_op(ACT_ARM, '0);
        for (a = 0; a < 4; a++)
            send_op(ACT_KICK, CORE_ID_W'(a));   // round closes on the fourth
        send_op(ACT_TICK, '0);
        send_op(ACT_DISABLE, '0);     // countdown holds
        send_op(ACT_KICK, 2'd1);      // marks while disarmed
        send_op(ACT_FORCE, '0);       // marks survive force-reset
        send_op(ACT_TICK, '0);
        wait_quiet(1000);
    endtask

    // Random phase: mostly structured bursts (kick rounds, force-and-expire,
    // tick runs) with arms, disables and raw noise mixed in.
    task automatic run_phase(input int target);
        int done_at;
        int kind;
        int n;
        int k;
        logic [CORE_ID_W-1:0] first;
        done_at = items_sent + target;
        while (items_sent < done_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                // walk the cores from a random start, ticks sprinkled in
                first = CORE_ID_W'($urandom);
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(0, 2) == 0)
                        send_op(ACT_TICK, CORE_ID_W'($urandom));
                    send_op(ACT_KICK, first + CORE_ID_W'(k));
                end
            end else if (kind < 60) begin
                send_op(ACT_FORCE, CORE_ID_W'($urandom));
                n = $urandom_range(6, 14);
                repeat (n) send_op(ACT_TICK, CORE_ID_W'($urandom));
            end else if (kind < 75) begin
                n = $urandom_range(1, 5);
                repeat (n) send_op(ACT_TICK, CORE_ID_W'($urandom));
            end else if (kind < 85) begin
                send_op(ACT_ARM, CORE_ID_W'($urandom));
            end else if (kind < 91) begin
                send_op(ACT_DISABLE, CORE_ID_W'($urandom));
            end else begin
                send_op(ACT_W'($urandom), CORE_ID_W'($urandom));
            end
        end
    endtask

    initial begin
        int p;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0: write_cfg(6'd15, 1'b0, 4'h0);
                1: write_cfg('1, 1'b1, '1);
                2: write_cfg(6'd1, 1'b1, 4'h0);    // empty mask: every kick closes
                3: write_cfg(6'd0, 1'b1, 4'h5);    // every arm rejected
                4: write_cfg(6'd16, 1'b0, 4'hA);   // just above the clamp
                default: write_cfg(TIMEOUT_W'($urandom), 1'($urandom), MARK_W'($urandom));
            endcase
            src_calm = ($urandom_range(0, 3) == 0);
            run_phase(PHASE_ITEMS);
            wait_quiet(5000);
        end

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
